/* hw/rtl/osc_b64_pkg.sv */
// ----------------------------------------------------------------------------
// osc_b64_pkg
// Shared types, character codes and the base64 alphabet lookup for the
// terminal envelope deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_b64_pkg;

   // Scanner modes of the byte stream parser.
   typedef enum logic [2:0] {
      MODE_RAW,
      MODE_AFTER_ESC,
      MODE_CODE,
      MODE_FLAG,
      MODE_BODY,
      MODE_BODY_ESC
   } mode_type;

   // Result word kinds as they appear on the response channel.
   typedef enum logic [1:0] {
      KIND_RAW     = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   localparam logic [7:0] CH_ESC      = 8'h1B;
   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_EQUALS   = 8'h3D;
   localparam logic [7:0] CH_SEMI     = 8'h3B;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_ONE      = 8'h31;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_SLASH    = 8'h2F;
   localparam logic [7:0] CH_UPPER_A  = 8'h41;
   localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CH_LOWER_A  = 8'h61;
   localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

   localparam logic [5:0] SEXTET_PLUS  = 6'd62;
   localparam logic [5:0] SEXTET_SLASH = 6'd63;
   localparam logic [7:0] LOWER_BASE   = 8'd26;
   localparam logic [7:0] DIGIT_BASE   = 8'd52;

   // At most three result words follow from one input byte.
   localparam int MAX_RESULTS  = 3;
   localparam int RESULT_DEPTH = 4;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   // Maps one character to its base64 value; ok is low outside the alphabet.
   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
         d = c - CH_UPPER_A;
         s.ok = 1'b1;
      end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
         d = c - CH_LOWER_A + LOWER_BASE;
         s.ok = 1'b1;
      end else if (c inside {[CH_ZERO:CH_NINE]}) begin
         d = c - CH_ZERO + DIGIT_BASE;
         s.ok = 1'b1;
      end else if (c == CH_PLUS) begin
         d = {2'b00, SEXTET_PLUS};
         s.ok = 1'b1;
      end else if (c == CH_SLASH) begin
         d = {2'b00, SEXTET_SLASH};
         s.ok = 1'b1;
      end
      s.value = d[5:0];
      return s;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/osc_envelope_base64_deframer.sv */
// ----------------------------------------------------------------------------
// osc_envelope_base64_deframer
// Splits a terminal byte stream into raw bytes and base64 decoded envelope
// payloads, closing each envelope with a message-end word.
// ----------------------------------------------------------------------------
// The request channel carries one stream byte per word. Bytes outside an
// envelope of the form ESC ] code ; flag ; body (ST or BEL) come back as raw
// words, but a header that breaks off is dropped. Body characters are decoded
// in quartets into payload words, and the terminator gives a message-end word
// with the code, the flag and the count of decoded bytes. Each word on the
// response channel marks whether it is the last one caused by its input byte.
// An accepted byte sits in an input register, is decoded there in a single
// pass, and its zero to three result words are written together into a
// four-word result queue, from which the first result is offered; while
// the queue lacks room the byte waits in the input register. One byte is
// taken in every cycle while the queue holds at most one word; a byte that
// yields three payload words therefore holds the request side while they
// drain, one word a cycle while the receiver does not stall, the rate set
// by the single read port of the queue.
// Reset empties the input register and the queue and returns the scanner to
// raw passthrough. When the receiver stalls, the head word is held unchanged;
// once the queue holds two words or more, req_stall rises for a waiting byte.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_envelope_base64_deframer #(
   parameter int CODE_BITS  = 16,
   parameter int COUNT_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_out_kind,
   output logic [7:0]            rsp_out_data,
   output logic [CODE_BITS-1:0]  rsp_osc_code,
   output logic                  rsp_is_compressed,
   output logic [COUNT_BITS-1:0] rsp_payload_len,
   output logic                  rsp_last_of_run
);
   import osc_b64_pkg::*;

   localparam int PTR_BITS  = $clog2(RESULT_DEPTH);
   localparam int FILL_BITS = $clog2(RESULT_DEPTH + 1);
   localparam logic [CODE_BITS+3:0] CODE_MAX_WIDE = {4'd0, {CODE_BITS{1'b1}}};
   localparam logic [COUNT_BITS:0]  COUNT_MAX_WIDE = {1'b0, {COUNT_BITS{1'b1}}};

   typedef struct packed {
      kind_type              kind;
      logic [7:0]            data;
      logic [CODE_BITS-1:0]  code;
      logic                  comp;
      logic [COUNT_BITS-1:0] len;
      logic                  last;
   } entry_type;

   function automatic entry_type make_entry(input kind_type k, input logic [7:0] d,
                                            input logic [CODE_BITS-1:0] cd, input logic cp,
                                            input logic [COUNT_BITS-1:0] ln);
      entry_type e;
      e.kind = k;
      e.data = d;
      e.code = cd;
      e.comp = cp;
      e.len  = ln;
      e.last = 1'b0;
      return e;
   endfunction

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Scanner state.
   mode_type              mode_ff, mode_in;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic                  flag_ff, flag_in;
   logic [5:0]            sx_ff [3];
   logic [5:0]            sx_in [3];
   logic [1:0]            carry_count_ff, carry_count_in;
   logic                  carry_invalid_ff, carry_invalid_in;
   logic                  pad_seen_ff, pad_seen_in;
   logic [COUNT_BITS-1:0] byte_count_ff, byte_count_in;

   // Result queue.
   entry_type            entry_ff [RESULT_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   entry_type res [MAX_RESULTS];
   logic [1:0] res_count;
   logic [1:0] pay_count;

   logic room, proc, accept, pop;
   logic [7:0] c;
   entry_type head;

   // The queue must hold the worst case of one byte before the byte is decoded.
   assign room      = fill_ff <= FILL_BITS'(RESULT_DEPTH - MAX_RESULTS);
   assign proc      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign c         = in_byte_ff;
   assign in_valid_in = accept || (in_valid_ff && !proc);

   // Next scanner mode.
   always_comb begin
      mode_in = mode_ff;
      case (mode_ff)
         MODE_AFTER_ESC: begin
            if (c == CH_RBRACKET) mode_in = MODE_CODE;
            else if (c == CH_ESC) mode_in = MODE_AFTER_ESC;
            else mode_in = MODE_RAW;
         end
         MODE_CODE: begin
            if (c inside {[CH_ZERO:CH_NINE]}) mode_in = MODE_CODE;
            else if (c == CH_SEMI) mode_in = MODE_FLAG;
            else mode_in = MODE_RAW;
         end
         MODE_FLAG: begin
            if (c inside {CH_ZERO, CH_ONE}) mode_in = MODE_FLAG;
            else if (c == CH_SEMI) mode_in = MODE_BODY;
            else mode_in = MODE_RAW;
         end
         MODE_BODY: begin
            if (c == CH_ESC) mode_in = MODE_BODY_ESC;
            else if (c == CH_BEL) mode_in = MODE_RAW;
            else mode_in = MODE_BODY;
         end
         MODE_BODY_ESC: begin
            if (c inside {CH_BSLASH, CH_BEL}) mode_in = MODE_RAW;
            else if (c == CH_ESC) mode_in = MODE_BODY_ESC;
            else mode_in = MODE_BODY;
         end
         default: begin
            if (c == CH_ESC) mode_in = MODE_AFTER_ESC;
            else mode_in = MODE_RAW;
         end
      endcase
   end

   // Decode datapath and result words.
   always_comb begin
      logic                 body_go;
      logic                 do_finish;
      logic [1:0]           cc;
      logic                 ci;
      logic                 ps;
      sextet_type           sv;
      logic [CODE_BITS+3:0] prod;
      logic [COUNT_BITS:0]  count_sum;

      body_go   = 1'b0;
      do_finish = 1'b0;
      cc        = carry_count_ff;
      ci        = carry_invalid_ff;
      ps        = pad_seen_ff;
      sv        = sextet_of(c);
      prod      = ({4'd0, code_ff} << 3) + ({4'd0, code_ff} << 1)
                  + (CODE_BITS + 4)'(c[3:0]);
      count_sum = '0;
      code_in   = code_ff;
      flag_in   = flag_ff;
      byte_count_in = byte_count_ff;
      for (int i = 0; i < 3; i++) sx_in[i] = sx_ff[i];
      for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
      res_count = '0;
      pay_count = '0;

      case (mode_ff)
         MODE_AFTER_ESC: begin
            if (c == CH_RBRACKET) begin
               code_in = '0;
               flag_in = 1'b0;
            end else begin
               // The held ESC was not an envelope opener.
               res[res_count] = make_entry(KIND_RAW, CH_ESC, '0, 1'b0, '0);
               res_count = res_count + 2'd1;
               if (c != CH_ESC) begin
                  res[res_count] = make_entry(KIND_RAW, c, '0, 1'b0, '0);
                  res_count = res_count + 2'd1;
               end
            end
         end
         MODE_CODE: begin
            if (c inside {[CH_ZERO:CH_NINE]}) begin
               code_in = (prod > CODE_MAX_WIDE) ? '1 : prod[CODE_BITS-1:0];
            end
         end
         MODE_FLAG: begin
            if (c inside {CH_ZERO, CH_ONE}) begin
               flag_in = (c == CH_ONE);
            end else if (c == CH_SEMI) begin
               cc = '0;
               ci = 1'b0;
               ps = 1'b0;
               byte_count_in = '0;
            end
         end
         MODE_BODY: begin
            body_go = 1'b1;
         end
         MODE_BODY_ESC: begin
            if (c == CH_BSLASH) begin
               do_finish = 1'b1;
            end else begin
               // A lone ESC in the body is an invalid character; it never
               // completes a usable quartet, so it gives no bytes.
               if (!ps) begin
                  ci = 1'b1;
                  if (cc != 2'd3) begin
                     sx_in[cc] = '0;
                     cc = cc + 2'd1;
                  end else begin
                     cc = '0;
                     ci = 1'b0;
                  end
               end
               body_go = 1'b1;
            end
         end
         default: begin
            if (c != CH_ESC) begin
               res[res_count] = make_entry(KIND_RAW, c, '0, 1'b0, '0);
               res_count = res_count + 2'd1;
            end
         end
      endcase

      if (body_go) begin
         if (c == CH_BEL) begin
            do_finish = 1'b1;
         end else if (c != CH_ESC && !ps) begin
            if (c == CH_EQUALS) begin
               // Padding completes a tail of two or three characters.
               if (!ci && cc >= 2'd2) begin
                  res[res_count] = make_entry(KIND_PAYLOAD, {sx_in[0], sx_in[1][5:4]},
                                              code_ff, flag_ff, '0);
                  res_count = res_count + 2'd1;
                  pay_count = pay_count + 2'd1;
                  if (cc == 2'd3) begin
                     res[res_count] = make_entry(KIND_PAYLOAD,
                                                 {sx_in[1][3:0], sx_in[2][5:2]},
                                                 code_ff, flag_ff, '0);
                     res_count = res_count + 2'd1;
                     pay_count = pay_count + 2'd1;
                  end
               end
               cc = '0;
               ci = 1'b0;
               ps = 1'b1;
            end else begin
               if (!sv.ok) ci = 1'b1;
               if (cc != 2'd3) begin
                  sx_in[cc] = sv.ok ? sv.value : 6'd0;
                  cc = cc + 2'd1;
               end else begin
                  if (!ci) begin
                     res[0] = make_entry(KIND_PAYLOAD, {sx_in[0], sx_in[1][5:4]},
                                         code_ff, flag_ff, '0);
                     res[1] = make_entry(KIND_PAYLOAD, {sx_in[1][3:0], sx_in[2][5:2]},
                                         code_ff, flag_ff, '0);
                     res[2] = make_entry(KIND_PAYLOAD, {sx_in[2][1:0], sv.value},
                                         code_ff, flag_ff, '0);
                     res_count = 2'd3;
                     pay_count = 2'd3;
                  end
                  cc = '0;
                  ci = 1'b0;
               end
            end
         end
      end

      if (pay_count != 2'd0) begin
         count_sum = {1'b0, byte_count_ff} + (COUNT_BITS + 1)'(pay_count);
         byte_count_in = (count_sum > COUNT_MAX_WIDE) ? '1 : count_sum[COUNT_BITS-1:0];
      end

      // The terminator never shares a byte with payload words.
      if (do_finish) begin
         res[res_count] = make_entry(KIND_END, 8'd0, code_ff, flag_ff, byte_count_ff);
         res_count = res_count + 2'd1;
         cc = '0;
         ci = 1'b0;
         ps = 1'b0;
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         res[i].last = (2'(i) + 2'd1 == res_count);
      end

      carry_count_in   = cc;
      carry_invalid_in = ci;
      pad_seen_in      = ps;
   end

   assign wr_ptr_in = wr_ptr_ff + (proc ? PTR_BITS'(res_count) : PTR_BITS'(0));
   assign rd_ptr_in = rd_ptr_ff + (pop ? PTR_BITS'(1) : PTR_BITS'(0));
   assign fill_in   = fill_ff - (pop ? FILL_BITS'(1) : FILL_BITS'(0))
                      + (proc ? FILL_BITS'(res_count) : FILL_BITS'(0));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         mode_ff          <= MODE_RAW;
         code_ff          <= '0;
         flag_ff          <= 1'b0;
         carry_count_ff   <= '0;
         carry_invalid_ff <= 1'b0;
         pad_seen_ff      <= 1'b0;
         byte_count_ff    <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         fill_ff          <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
         if (proc) begin
            mode_ff          <= mode_in;
            code_ff          <= code_in;
            flag_ff          <= flag_in;
            carry_count_ff   <= carry_count_in;
            carry_invalid_ff <= carry_invalid_in;
            pad_seen_ff      <= pad_seen_in;
            byte_count_ff    <= byte_count_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
      end
      if (proc) begin
         for (int i = 0; i < 3; i++) sx_ff[i] <= sx_in[i];
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < res_count) begin
               entry_ff[wr_ptr_ff + PTR_BITS'(i)] <= res[i];
            end
         end
      end
   end

   assign head              = entry_ff[rd_ptr_ff];
   assign rsp_valid         = fill_ff != '0;
   assign rsp_out_kind      = head.kind;
   assign rsp_out_data      = head.data;
   assign rsp_osc_code      = head.code;
   assign rsp_is_compressed = head.comp;
   assign rsp_payload_len   = head.len;
   assign rsp_last_of_run   = head.last;

endmodule

`default_nettype wire

/* hw/rtl/osc_b64_checker.sv */
// ----------------------------------------------------------------------------
// osc_b64_checker
// Port-level checks on the result words of the envelope deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_b64_checker #(
   parameter int CODE_BITS  = 16,
   parameter int COUNT_BITS = 20
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [1:0]            rsp_out_kind,
   input wire logic [7:0]            rsp_out_data,
   input wire logic [CODE_BITS-1:0]  rsp_osc_code,
   input wire logic                  rsp_is_compressed,
   input wire logic [COUNT_BITS-1:0] rsp_payload_len,
   input wire logic                  rsp_last_of_run
);
   import osc_b64_pkg::*;

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind == KIND_RAW || rsp_out_kind == KIND_PAYLOAD ||
                     rsp_out_kind == KIND_END))
      else $error("result word with an undefined kind");

   a_len_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_END |-> rsp_payload_len == '0)
      else $error("byte count shown on a data word");

   a_raw_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_RAW |-> rsp_osc_code == '0 && !rsp_is_compressed)
      else $error("raw word carries envelope fields");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_END |-> rsp_out_data == 8'd0 && rsp_last_of_run)
      else $error("message end is not the closing word of its byte");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_out_kind, rsp_out_data, rsp_osc_code, rsp_is_compressed,
                  rsp_payload_len, rsp_last_of_run}))
      else $error("stalled result word changed");

endmodule

bind osc_envelope_base64_deframer osc_b64_checker #(
   .CODE_BITS(CODE_BITS),
   .COUNT_BITS(COUNT_BITS)
) u_osc_b64_checker (.*);

`default_nettype wire

/* verif/osc_envelope_base64_deframer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// osc_envelope_base64_deframer_tb
// Self-checking bench for the terminal envelope deframer. A short scripted
// stream and then random streams, mostly well formed envelopes, are fed in
// under three idling mixes. Every result word is checked in order against a
// behavioural decoder that the bench keeps alongside the block.
// ----------------------------------------------------------------------------

module osc_envelope_base64_deframer_tb;
   import osc_b64_pkg::*;

   // One result word as the response channel presents it.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] code;
      logic        comp;
      logic [19:0] len;
      logic        last;
   } result_word_type;

   // One line of the scripted stream. Where typed is set, the word given here
   // (or no word at all) is what the block must return for the byte, and the
   // decoder only follows along to keep its state in step.
   typedef struct {
      logic [7:0]      in_byte;
      bit              typed;
      bit              yields;
      result_word_type word;
   } script_row_type;

   localparam logic [15:0] CODE_MAX         = '1;
   localparam logic [19:0] COUNT_MAX        = '1;
   localparam int          RANDOM_PER_PHASE = 45;
   localparam int          LONG_HOLD_CYCLES = 64;
   localparam int          SETTLE_CYCLES    = 12;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_data;
   logic [15:0] rsp_osc_code;
   logic        rsp_is_compressed;
   logic [19:0] rsp_payload_len;
   logic        rsp_last_of_run;

   // Words the block still owes, oldest first, and the words of the last byte.
   result_word_type awaited_words[$];
   result_word_type step_words[$];
   logic [7:0]      burst[$];
   script_row_type  script[$];

   // Behavioural decoder state, mirroring what the block must hold.
   mode_type    dec_mode   = MODE_RAW;
   logic [15:0] dec_code   = '0;
   logic        dec_flag   = 1'b0;
   logic [5:0]  dec_sextet [3] = '{default: 6'd0};
   int unsigned dec_held   = 0;
   logic        dec_bad    = 1'b0;
   logic        dec_padded = 1'b0;
   logic [19:0] dec_count  = '0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   bit hold_req       = 1'b0;
   int failures       = 0;
   int bytes_sent     = 0;
   int words_seen     = 0;
   int payload_seen   = 0;
   int ends_seen      = 0;
   int envelopes_sent = 0;
   int burst_ignored  = 0;

   osc_envelope_base64_deframer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_data      (rsp_out_data),
      .rsp_osc_code      (rsp_osc_code),
      .rsp_is_compressed (rsp_is_compressed),
      .rsp_payload_len   (rsp_payload_len),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Behavioural decoder
   // -------------------------------------------------------------------------

   function automatic result_word_type mk_word(input kind_type kind,
                                               input logic [7:0] data,
                                               input logic [15:0] code, input logic comp,
                                               input logic [19:0] len);
      result_word_type w;
      w.kind = kind;
      w.data = data;
      w.code = code;
      w.comp = comp;
      w.len  = len;
      w.last = 1'b1;
      return w;
   endfunction

   // Value of a base64 character, or -1 for anything outside the alphabet.
   function automatic int b64_value(input logic [7:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c - CH_UPPER_A);
      if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c - CH_LOWER_A) + int'(LOWER_BASE);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO) + int'(DIGIT_BASE);
      if (c == CH_PLUS) return int'(SEXTET_PLUS);
      if (c == CH_SLASH) return int'(SEXTET_SLASH);
      return -1;
   endfunction

   function automatic void emit_word(input kind_type kind, input logic [7:0] data,
                                     input logic [15:0] code, input logic comp,
                                     input logic [19:0] len);
      result_word_type w;
      w = mk_word(kind, data, code, comp, len);
      w.last = 1'b0;
      step_words.push_back(w);
   endfunction

   // A decoded byte also advances the envelope's byte count, which sticks at
   // its maximum rather than wrapping.
   function automatic void emit_payload(input logic [7:0] b);
      if (dec_count != COUNT_MAX) dec_count++;
      emit_word(KIND_PAYLOAD, b, dec_code, dec_flag, '0);
   endfunction

   function automatic void decode_body_char(input logic [7:0] c);
      int v;
      // Once padding has been seen the rest of the body is of no interest.
      if (dec_padded) return;
      if (c == CH_EQUALS) begin
         // Padding flushes a held tail of two or three characters.
         if (!dec_bad && dec_held >= 2) begin
            emit_payload({dec_sextet[0], dec_sextet[1][5:4]});
            if (dec_held == 3) emit_payload({dec_sextet[1][3:0], dec_sextet[2][5:2]});
         end
         dec_held   = 0;
         dec_bad    = 1'b0;
         dec_padded = 1'b1;
      end else begin
         v = b64_value(c);
         if (v < 0) begin
            dec_bad = 1'b1;
            v       = 0;
         end
         if (dec_held < 3) begin
            dec_sextet[dec_held] = v[5:0];
            dec_held++;
         end else begin
            // A quartet with any character outside the alphabet yields nothing.
            if (!dec_bad) begin
               emit_payload({dec_sextet[0], dec_sextet[1][5:4]});
               emit_payload({dec_sextet[1][3:0], dec_sextet[2][5:2]});
               emit_payload({dec_sextet[2][1:0], v[5:0]});
            end
            dec_held = 0;
            dec_bad  = 1'b0;
         end
      end
   endfunction

   // Any characters still held at the terminator are simply dropped.
   function automatic void close_envelope();
      emit_word(KIND_END, 8'h00, dec_code, dec_flag, dec_count);
      dec_held   = 0;
      dec_bad    = 1'b0;
      dec_padded = 1'b0;
      dec_mode   = MODE_RAW;
   endfunction

   function automatic void decode_body_byte(input logic [7:0] c);
      if (c == CH_ESC) dec_mode = MODE_BODY_ESC;
      else if (c == CH_BEL) close_envelope();
      else decode_body_char(c);
   endfunction

   function automatic void decode_raw_byte(input logic [7:0] c);
      if (c == CH_ESC) dec_mode = MODE_AFTER_ESC;
      else emit_word(KIND_RAW, c, '0, 1'b0, '0);
   endfunction

   // Works out the words caused by one stream byte into step_words.
   function automatic void decode_stream_byte(input logic [7:0] c);
      int unsigned     acc;
      result_word_type tail_word;
      step_words.delete();
      case (dec_mode)
         MODE_AFTER_ESC: begin
            if (c == CH_RBRACKET) begin
               dec_code = '0;
               dec_flag = 1'b0;
               dec_mode = MODE_CODE;
            end else begin
               // The escape was not an envelope opener and goes out as is; the
               // byte after it is taken as a fresh raw byte.
               emit_word(KIND_RAW, CH_ESC, '0, 1'b0, '0);
               dec_mode = MODE_RAW;
               decode_raw_byte(c);
            end
         end
         MODE_CODE: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
               acc      = int'(dec_code) * 10 + int'(c - CH_ZERO);
               dec_code = (acc > int'(CODE_MAX)) ? CODE_MAX : acc[15:0];
            end else if (c == CH_SEMI) begin
               dec_mode = MODE_FLAG;
            end else begin
               dec_mode = MODE_RAW;
            end
         end
         MODE_FLAG: begin
            if (c == CH_ZERO || c == CH_ONE) begin
               dec_flag = (c == CH_ONE);
            end else if (c == CH_SEMI) begin
               dec_held   = 0;
               dec_bad    = 1'b0;
               dec_padded = 1'b0;
               dec_count  = '0;
               dec_mode   = MODE_BODY;
            end else begin
               dec_mode = MODE_RAW;
            end
         end
         MODE_BODY: begin
            decode_body_byte(c);
         end
         MODE_BODY_ESC: begin
            if (c == CH_BSLASH) begin
               close_envelope();
            end else begin
               // A lone escape counts as a bad body character.
               decode_body_char(CH_ESC);
               dec_mode = MODE_BODY;
               decode_body_byte(c);
            end
         end
         default: begin
            dec_mode = MODE_RAW;
            decode_raw_byte(c);
         end
      endcase
      if (step_words.size() != 0) begin
         tail_word      = step_words.pop_back();
         tail_word.last = 1'b1;
         step_words.push_back(tail_word);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   function automatic script_row_type row(input logic [7:0] b);
      script_row_type r;
      r.in_byte = b;
      r.typed   = 1'b0;
      r.yields  = 1'b0;
      r.word    = '0;
      return r;
   endfunction

   function automatic script_row_type typed_row(input logic [7:0] b, input bit yields,
                                                input result_word_type w);
      script_row_type r;
      r.in_byte = b;
      r.typed   = 1'b1;
      r.yields  = yields;
      r.word    = w;
      return r;
   endfunction

   function automatic logic [7:0] b64_char(input int v);
      if (v < int'(LOWER_BASE)) return CH_UPPER_A + 8'(v);
      if (v < int'(DIGIT_BASE)) return CH_LOWER_A + 8'(v - int'(LOWER_BASE));
      if (v < int'(SEXTET_PLUS)) return CH_ZERO + 8'(v - int'(DIGIT_BASE));
      if (v == int'(SEXTET_PLUS)) return CH_PLUS;
      return CH_SLASH;
   endfunction

   // Body characters are mostly from the alphabet, with the odd lone escape
   // and the odd arbitrary byte, which may spoil a quartet or even end the
   // envelope early.
   function automatic void push_body_char();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) burst.push_back(CH_ESC);
      else if (pick == 1) burst.push_back(8'($urandom_range(255)));
      else burst.push_back(b64_char($urandom_range(63)));
   endfunction

   // Queues one stretch of stream: a well formed envelope with random content
   // most of the time, otherwise loose bytes or a broken envelope opening.
   function automatic void queue_segment();
      int         pick;
      int         n;
      logic [7:0] b;
      pick          = $urandom_range(9);
      burst_ignored = 0;
      if (pick <= 5) begin
         envelopes_sent++;
         burst.push_back(CH_ESC);
         burst.push_back(CH_RBRACKET);
         // Up to six digits, so long codes run into saturation.
         n = $urandom_range(6);
         repeat (n) burst.push_back(CH_ZERO + 8'($urandom_range(9)));
         burst.push_back(CH_SEMI);
         // Empty, single or repeated flag digits.
         n = $urandom_range(3);
         repeat (n) burst.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
         burst.push_back(CH_SEMI);
         // Whole quartets and then a tail of nought to three characters.
         n = 4 * $urandom_range(3) + $urandom_range(3);
         repeat (n) push_body_char();
         if ($urandom_range(1)) begin
            burst.push_back(CH_EQUALS);
            n             = $urandom_range(2);
            burst_ignored = n;
            repeat (n) burst.push_back($urandom_range(1) ? CH_EQUALS : b64_char($urandom_range(63)));
         end
         if ($urandom_range(1)) begin
            burst.push_back(CH_BEL);
         end else begin
            burst.push_back(CH_ESC);
            burst.push_back(CH_BSLASH);
         end
      end else if (pick <= 7) begin
         n = $urandom_range(4, 1);
         repeat (n) burst.push_back(8'($urandom_range(255)));
      end else begin
         burst.push_back(CH_ESC);
         n = $urandom_range(2);
         if (n == 0) begin
            b = 8'($urandom_range(255));
            if (b == CH_RBRACKET) b = CH_BEL;
            burst.push_back(b);
         end else begin
            burst.push_back(CH_RBRACKET);
            repeat ($urandom_range(3)) burst.push_back(CH_ZERO + 8'($urandom_range(9)));
            if (n == 2) begin
               burst.push_back(CH_SEMI);
               repeat ($urandom_range(2)) burst.push_back($urandom_range(1) ? CH_ONE : CH_ZERO);
            end
            // A letter is neither a digit nor a separator, so the header drops.
            burst.push_back(CH_UPPER_A + 8'($urandom_range(25)));
         end
      end
   endfunction

   // Offers one byte, possibly after an idle gap, and records what it owes
   // once the block has taken it.
   task automatic send_byte(input logic [7:0] b, input bit typed, input bit yields,
                            input result_word_type typed_word);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      decode_stream_byte(b);
      if (typed) begin
         if (yields) awaited_words.push_back(typed_word);
      end else begin
         foreach (step_words[i]) awaited_words.push_back(step_words[i]);
      end
      bytes_sent++;
   endtask

   task automatic send_burst();
      while (burst.size() != 0) send_byte(burst.pop_front(), 1'b0, 1'b0, '0);
   endtask

   // One random phase under a given idling mix. At its end the sender rests
   // until the block has handed back every word that it owes.
   task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
      int items;
      items         = 0;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      if (long_hold) hold_req = 1'b1;
      while (items < RANDOM_PER_PHASE) begin
         queue_segment();
         items += burst.size() - burst_ignored;
         send_burst();
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_words.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stalls, and on request one long hold-off while the
   // sender keeps offering bytes, so that the result queue fills and the block
   // has to push back on its input.
   // -------------------------------------------------------------------------
   initial begin : stall_driver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Checker: each word taken from the block must match the oldest word owed.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : word_checker
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = kind_type'(rsp_out_kind);
         got.data = rsp_out_data;
         got.code = rsp_osc_code;
         got.comp = rsp_is_compressed;
         got.len  = rsp_payload_len;
         got.last = rsp_last_of_run;
         words_seen++;
         if (got.kind == KIND_PAYLOAD) payload_seen++;
         if (got.kind == KIND_END) ends_seen++;
         if (awaited_words.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Unexpected word at %0t ns: kind %0d data %02h code %0d len %0d",
                        $time, got.kind, got.data, got.code, got.len);
            end
         end else begin
            want = awaited_words.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= 10) begin
                  $display("Mismatch at %0t ns", $time);
                  $display("  expected kind %0d data %02h code %0d comp %0b len %0d last %0b",
                           want.kind, want.data, want.code, want.comp, want.len, want.last);
                  $display("  actual kind %0d data %02h code %0d comp %0b len %0d last %0b",
                           got.kind, got.data, got.code, got.comp, got.len, got.last);
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      // Scripted stream. Straight after reset the extremes of the byte range
      // come back raw; an escape followed by another escape lets the first go
      // out raw and opens a fresh check with the second. The envelope then has
      // a code that saturates, repeated flag digits where the last one wins, a
      // full quartet, a lone escape spoiling a padded tail, a character after
      // the padding that is ignored, and an ST terminator. Last comes a header
      // whose flag field is malformed, which is swallowed.
      script.push_back(typed_row(8'h00, 1'b1, mk_word(KIND_RAW, 8'h00, '0, 1'b0, '0)));
      script.push_back(typed_row(8'hFF, 1'b1, mk_word(KIND_RAW, 8'hFF, '0, 1'b0, '0)));
      script.push_back(typed_row(CH_ESC, 1'b0, '0));
      script.push_back(typed_row(CH_ESC, 1'b1, mk_word(KIND_RAW, CH_ESC, '0, 1'b0, '0)));
      script.push_back(row(CH_RBRACKET));
      repeat (5) script.push_back(row(CH_NINE));
      script.push_back(row(CH_SEMI));
      script.push_back(row(CH_ONE));
      script.push_back(row(CH_ZERO));
      script.push_back(row(CH_SEMI));
      script.push_back(row("Q"));
      script.push_back(row("U"));
      script.push_back(row("J"));
      script.push_back(row("D"));
      script.push_back(row(CH_ESC));
      script.push_back(row("T"));
      script.push_back(row("W"));
      script.push_back(row(CH_EQUALS));
      script.push_back(row("Z"));
      script.push_back(row(CH_ESC));
      script.push_back(typed_row(CH_BSLASH, 1'b1,
                                 mk_word(KIND_END, 8'h00, CODE_MAX, 1'b0, 20'd3)));
      script.push_back(row(CH_ESC));
      script.push_back(row(CH_RBRACKET));
      script.push_back(row(CH_SEMI));
      script.push_back(row(CH_SLASH));

      send_idle_pct = 23;
      recv_idle_pct = 57;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send_byte(script[i].in_byte, script[i].typed, script[i].yields, script[i].word);
      end

      // Random streams: a slow receiver first, then a slow sender, then full
      // rate on both sides with one long receiver hold-off.
      run_phase(23, 57, 1'b0);
      run_phase(57, 23, 1'b0);
      run_phase(0, 0, 1'b1);

      // Give any stray word time to show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d stream bytes (%0d scripted) and %0d random envelopes,",
               bytes_sent, script.size(), envelopes_sent);
      $display("returning %0d words: %0d decoded payload bytes and %0d message ends.",
               words_seen, payload_seen, ends_seen);
      if (failures == 0 && awaited_words.size() == 0) begin
         $display("PASS osc_envelope_base64_deframer");
      end else begin
         $display("FAIL osc_envelope_base64_deframer");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin : watchdog
      #400_000;
      $display("Timed out with %0d words still owed.", awaited_words.size());
      $display("FAIL osc_envelope_base64_deframer");
      $finish;
   end

endmodule
